[hdl/dws_pkg.sv]
// Shared types and constants for the diamond window sum block.
`timescale 1ns / 1ps
`default_nettype none
package dws_pkg;

  localparam int SUM_W       = 24;
  localparam int COUNT_W     = 17;
  localparam int CENTER_W    = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_MAX     = 8388607;
  localparam int SUM_MIN     = -8388608;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS = 2'd0,
    CFG_FRAME_COLS = 2'd1,
    CFG_RADIUS     = 2'd2
  } cfg_idx_t;

  // Per-beat classification handed from the scan side to the window side.
  typedef struct packed {
    logic                emit;
    logic                restart;
    logic                col_zero;
    logic                last;
    logic [CENTER_W-1:0] center_row;
    logic [CENTER_W-1:0] center_col;
  } beat_ctl_t;

  typedef struct packed {
    logic [CENTER_W-1:0]      center_row;
    logic [CENTER_W-1:0]      center_col;
    logic signed [SUM_W-1:0]  window_sum;
    logic signed [SUM_W-1:0]  best_sum;
    logic [COUNT_W-1:0]       best_count;
    logic                     last;
  } result_t;

endpackage
`default_nettype wire

[hdl/dws_in_if.sv]
// Input channel: one raster beat per word.
`timescale 1ns / 1ps
`default_nettype none
interface dws_in_if #(parameter int PW = 16);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic signed [PW-1:0] pixel_value;
  modport source(output valid, req_type, pixel_value, input ready);
  modport sink(input valid, req_type, pixel_value, output ready);
endinterface
`default_nettype wire

[hdl/dws_out_if.sv]
// Output channel: one window result per word.
`timescale 1ns / 1ps
`default_nettype none
interface dws_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         center_row;
  logic [7:0]         center_col;
  logic signed [23:0] window_sum;
  logic signed [23:0] best_sum;
  logic [16:0]        best_count;
  logic               last;
  modport source(output valid, center_row, center_col, window_sum, best_sum, best_count,
                 last, input ready);
  modport sink(input valid, center_row, center_col, window_sum, best_sum, best_count,
               last, output ready);
endinterface
`default_nettype wire

[hdl/diamond_window_sum_max.sv]
// Throughput: one beat per clock; a stalled result output holds the scan side back via the queue.
// A window result is offered once the beat that completes it (radius rows and columns into
// the scan) has passed the line bank read, the queue, the window register, the four adder
// stages and the output buffer.
// Reset: synchronous; scan position, best sum and count are cleared, line banks are not,
// since every cell a window reads is written earlier in the same frame.
`timescale 1ns / 1ps
`default_nettype none
module diamond_window_sum_max #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int MAX_RADIUS  = 8,
  parameter int PIXEL_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  dws_in_if.sink                                pix_in,
  dws_out_if.source                             res_out,
  input  wire logic                             cfg_we,
  input  wire logic [dws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dws_pkg::CFG_W-1:0]        cfg_data
);
  import dws_pkg::*;

  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int RDW  = $clog2(MAX_RADIUS + 1);
  localparam int WIN  = 2 * MAX_RADIUS + 1;
  localparam int COLW = WIN * PIXEL_WIDTH;
  localparam int QW   = COLW + $bits(beat_ctl_t);

  logic [RW-1:0]  frame_rows;
  logic [CW-1:0]  frame_cols;
  logic [RDW-1:0] radius;
  logic           restart;

  logic                       push;
  beat_ctl_t                  push_ctl;
  logic [COLW-1:0]            push_col;
  logic [QW-1:0]              q_head;
  logic                       q_valid;
  logic                       q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  beat_ctl_t                  q_ctl;
  logic [COLW-1:0]            q_col;

  assign restart = cfg_we && ((cfg_index == CFG_FRAME_ROWS) || (cfg_index == CFG_FRAME_COLS) ||
                              (cfg_index == CFG_RADIUS));

  // Zero reads as one and large values saturate at the build maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= RW'(1);
      frame_cols <= CW'(1);
      radius     <= RDW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_ROWS: begin
          if (cfg_data == '0) frame_rows <= RW'(1);
          else if (int'(cfg_data) > MAX_ROWS) frame_rows <= RW'(MAX_ROWS);
          else frame_rows <= RW'(cfg_data);
        end
        CFG_FRAME_COLS: begin
          if (cfg_data == '0) frame_cols <= CW'(1);
          else if (int'(cfg_data) > MAX_COLS) frame_cols <= CW'(MAX_COLS);
          else frame_cols <= CW'(cfg_data);
        end
        CFG_RADIUS: begin
          if (cfg_data == '0) radius <= RDW'(1);
          else if (int'(cfg_data) > MAX_RADIUS) radius <= RDW'(MAX_RADIUS);
          else radius <= RDW'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  dws_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
    .MAX_RADIUS(MAX_RADIUS), .PIXEL_WIDTH(PIXEL_WIDTH)
  ) u_front (
    .clk(clk), .rst(rst), .pix_in(pix_in),
    .frame_rows(frame_rows), .frame_cols(frame_cols), .radius(radius),
    .restart(restart), .q_count(q_count),
    .push(push), .push_ctl(push_ctl), .push_col(push_col)
  );

  dws_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst || restart),
    .push(push), .push_data({push_ctl, push_col}),
    .pop(q_pop), .head(q_head), .not_empty(q_valid), .count(q_count)
  );

  assign q_ctl = q_head[QW-1:COLW];
  assign q_col = q_head[COLW-1:0];

  dws_back #(.MAX_RADIUS(MAX_RADIUS), .PIXEL_WIDTH(PIXEL_WIDTH)) u_back (
    .clk(clk), .rst(rst), .restart(restart), .radius(radius),
    .q_valid(q_valid), .q_ctl(q_ctl), .q_col(q_col), .q_pop(q_pop),
    .res_out(res_out)
  );
endmodule
`default_nettype wire

[hdl/dws_queue.sv]
// Small word queue between the scan front and the window back end.
`timescale 1ns / 1ps
`default_nettype none
module dws_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [W-1:0]               push_data,
  input  wire logic                       pop,
  output logic      [W-1:0]               head,
  output logic                            not_empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/dws_front.sv]
// Scan front: tracks the raster position, keeps the line banks, classifies each beat.
`timescale 1ns / 1ps
`default_nettype none
module dws_front #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int MAX_RADIUS  = 8,
  parameter int PIXEL_WIDTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  dws_in_if.sink                                           pix_in,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]               frame_rows,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]               frame_cols,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0]             radius,
  input  wire logic                                        restart,
  input  wire logic [$clog2(dws_pkg::QUEUE_DEPTH+1)-1:0]   q_count,
  output logic                                             push,
  output dws_pkg::beat_ctl_t                               push_ctl,
  output logic [(2*MAX_RADIUS+1)*PIXEL_WIDTH-1:0]          push_col
);
  import dws_pkg::*;

  localparam int WIN  = 2 * MAX_RADIUS + 1;
  localparam int BW   = $clog2(WIN);
  localparam int SRW  = $clog2(MAX_ROWS + MAX_RADIUS + 1);
  localparam int SCW  = $clog2(MAX_COLS + MAX_RADIUS + 1);
  localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);

  logic [SRW-1:0] scan_row;
  logic [SCW-1:0] scan_col;
  logic [BW-1:0]  scan_bank;

  logic                   accept;
  logic [SRW:0]           row_x, rows_x, rad_r;
  logic [SCW:0]           col_x, cols_x, rad_c;
  logic                   in_frame;
  logic signed [PIXEL_WIDTH-1:0] pix_val;
  logic [WIN-1:0]         row_ok;
  beat_ctl_t              ctl_a;
  logic [SRW:0]           crow;
  logic [SCW:0]           ccol;

  // One bank per ring row; every bank is read at the scan column on each beat.
  logic signed [PIXEL_WIDTH-1:0] banks [WIN][MAX_COLS];
  logic signed [PIXEL_WIDTH-1:0] rd [WIN];

  logic                          b_valid;
  logic [WIN-1:0]                b_row_ok;
  logic                          b_col_ok;
  logic signed [PIXEL_WIDTH-1:0] b_pix;
  logic [BW-1:0]                 b_bank;
  beat_ctl_t                     b_ctl;
  logic [BW:0]                   sel [WIN];

  assign pix_in.ready = ({1'b0, q_count} + {{QCW{1'b0}}, b_valid}) < (QCW+1)'(QUEUE_DEPTH);
  assign accept       = pix_in.valid && pix_in.ready;

  always_comb begin
    row_x    = {1'b0, scan_row};
    col_x    = {1'b0, scan_col};
    rows_x   = (SRW+1)'(frame_rows);
    cols_x   = (SCW+1)'(frame_cols);
    rad_r    = (SRW+1)'(radius);
    rad_c    = (SCW+1)'(radius);
    in_frame = (row_x < rows_x) && (col_x < cols_x);
    pix_val  = (in_frame && !pix_in.req_type) ? pix_in.pixel_value : '0;
    for (int k = 0; k < WIN; k++) begin
      row_ok[k] = (row_x >= (SRW+1)'(k)) && (row_x < rows_x + (SRW+1)'(k));
    end
    crow               = row_x - rad_r;
    ccol               = col_x - rad_c;
    ctl_a.emit         = (row_x >= rad_r) && (row_x < rows_x + rad_r) &&
                         (col_x >= rad_c) && (col_x < cols_x + rad_c);
    ctl_a.restart      = (scan_row == '0) && (scan_col == '0);
    ctl_a.col_zero     = (scan_col == '0);
    ctl_a.last         = (row_x + 1'b1 == rows_x + rad_r) && (col_x + 1'b1 == cols_x + rad_c);
    ctl_a.center_row   = CENTER_W'(crow);
    ctl_a.center_col   = CENTER_W'(ccol);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int b = 0; b < WIN; b++) begin
        if (in_frame && (scan_bank == BW'(b))) begin
          banks[b][scan_col[AW-1:0]] <= pix_val;
        end
        rd[b] <= banks[b][scan_col[AW-1:0]];
      end
      b_row_ok <= row_ok;
      b_col_ok <= (col_x < cols_x);
      b_pix    <= pix_val;
      b_bank   <= scan_bank;
      b_ctl    <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      scan_row  <= '0;
      scan_col  <= '0;
      scan_bank <= '0;
      b_valid   <= 1'b0;
    end else begin
      b_valid <= accept;
      if (accept) begin
        if (col_x + 1'b1 >= cols_x + rad_c) begin
          scan_col <= '0;
          if (row_x + 1'b1 >= rows_x + rad_r) begin
            scan_row  <= '0;
            scan_bank <= '0;
          end else begin
            scan_row  <= scan_row + 1'b1;
            scan_bank <= (scan_bank == BW'(WIN - 1)) ? '0 : scan_bank + 1'b1;
          end
        end else begin
          scan_col <= scan_col + 1'b1;
        end
      end
    end
  end

  // Row k of the column sits k rows above the current one, in bank (bank - k) mod ring.
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      sel[k] = {1'b0, b_bank} + (BW+1)'(WIN - k);
      if (sel[k] >= (BW+1)'(WIN)) begin
        sel[k] = sel[k] - (BW+1)'(WIN);
      end
    end
    push_col = '0;
    for (int k = 0; k < WIN; k++) begin
      if (b_col_ok && b_row_ok[k]) begin
        if (k == 0) begin
          push_col[k*PIXEL_WIDTH +: PIXEL_WIDTH] = b_pix;
        end else begin
          for (int b = 0; b < WIN; b++) begin
            if (sel[k][BW-1:0] == BW'(b)) begin
              push_col[k*PIXEL_WIDTH +: PIXEL_WIDTH] = rd[b];
            end
          end
        end
      end
    end
  end

  assign push     = b_valid;
  assign push_ctl = b_ctl;
endmodule
`default_nettype wire

[hdl/dws_back.sv]
// Window back end: shifting window, pipelined diamond sum, running best and output buffer.
`timescale 1ns / 1ps
`default_nettype none
module dws_back #(
  parameter int MAX_RADIUS  = 8,
  parameter int PIXEL_WIDTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    restart,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0]         radius,
  input  wire logic                                    q_valid,
  input  wire dws_pkg::beat_ctl_t                      q_ctl,
  input  wire logic [(2*MAX_RADIUS+1)*PIXEL_WIDTH-1:0] q_col,
  output logic                                         q_pop,
  dws_out_if.source                                    res_out
);
  import dws_pkg::*;

  localparam int WIN  = 2 * MAX_RADIUS + 1;
  localparam int G    = 6;
  localparam int NG   = (WIN + G - 1) / G;
  localparam int ACCW = PIXEL_WIDTH + $clog2(WIN * WIN) + 1;
  localparam int EW   = (ACCW > SUM_W) ? ACCW : SUM_W + 1;
  localparam int DW   = $clog2(WIN) + 1;
  localparam logic signed [EW-1:0] SAT_HI = EW'(SUM_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(SUM_MIN);

  function automatic logic [DW-1:0] absd(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  logic en;
  logic msk [WIN][WIN];
  logic signed [PIXEL_WIDTH-1:0] win [WIN][WIN];

  logic vw, v1, v2, v3, v4;
  beat_ctl_t ctl_w, ctl1, ctl2, ctl3, ctl4;

  logic signed [ACCW-1:0] s1_next [WIN][NG];
  logic signed [ACCW-1:0] s1 [WIN][NG];
  logic signed [ACCW-1:0] s2_next [WIN];
  logic signed [ACCW-1:0] s2 [WIN];
  logic signed [ACCW-1:0] s3_next [NG];
  logic signed [ACCW-1:0] s3 [NG];
  logic signed [EW-1:0]   tot;
  logic signed [SUM_W-1:0] s4;

  logic signed [SUM_W-1:0] best, best_next;
  logic [COUNT_W-1:0]      count, count_next;

  result_t obuf [2];
  logic    owp, orp;
  logic [1:0] ocount;
  logic    opush, opop;

  assign opop  = res_out.valid && res_out.ready;
  assign en    = (ocount != 2'd2) || res_out.ready;
  assign q_pop = en && q_valid;

  // Diamond shape for the current radius, centred at window offset (radius, radius).
  always_ff @(posedge clk) begin
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN; j++) begin
        msk[k][j] <= (absd(DW'(k), DW'(radius)) + absd(DW'(j), DW'(radius))) <= DW'(radius);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < WIN; k++) begin
        win[k][0] <= q_col[k*PIXEL_WIDTH +: PIXEL_WIDTH];
        for (int j = 1; j < WIN; j++) begin
          win[k][j] <= q_ctl.col_zero ? '0 : win[k][j-1];
        end
      end
    end
    if (en) begin
      ctl_w <= q_ctl;
      ctl1  <= ctl_w;
      ctl2  <= ctl1;
      ctl3  <= ctl2;
      ctl4  <= ctl3;
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      if (tot > SAT_HI) begin
        s4 <= SUM_W'(SAT_HI);
      end else if (tot < SAT_LO) begin
        s4 <= SUM_W'(SAT_LO);
      end else begin
        s4 <= SUM_W'(tot);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int g = 0; g < NG; g++) begin
        s1_next[k][g] = '0;
        for (int j = 0; j < WIN; j++) begin
          if ((j / G == g) && msk[k][j]) begin
            s1_next[k][g] = s1_next[k][g] + ACCW'(win[k][j]);
          end
        end
      end
    end
    for (int k = 0; k < WIN; k++) begin
      s2_next[k] = '0;
      for (int g = 0; g < NG; g++) begin
        s2_next[k] = s2_next[k] + s1[k][g];
      end
    end
    for (int g = 0; g < NG; g++) begin
      s3_next[g] = '0;
      for (int k = 0; k < WIN; k++) begin
        if (k / G == g) begin
          s3_next[g] = s3_next[g] + s2[k];
        end
      end
    end
    tot = '0;
    for (int g = 0; g < NG; g++) begin
      tot = tot + EW'(s3[g]);
    end
  end

  always_comb begin
    best_next  = best;
    count_next = count;
    if (ctl4.restart) begin
      best_next  = SUM_W'(SUM_MIN);
      count_next = '0;
    end
    if (ctl4.emit) begin
      if ((count_next == '0) || (s4 > best_next)) begin
        best_next  = s4;
        count_next = COUNT_W'(1);
      end else if ((s4 == best_next) && (count_next != {COUNT_W{1'b1}})) begin
        count_next = count_next + 1'b1;
      end
    end
  end

  assign opush = en && v4 && ctl4.emit;

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf[owp].center_row <= ctl4.center_row;
      obuf[owp].center_col <= ctl4.center_col;
      obuf[owp].window_sum <= s4;
      obuf[owp].best_sum   <= best_next;
      obuf[owp].best_count <= count_next;
      obuf[owp].last       <= ctl4.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vw     <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      best   <= SUM_W'(SUM_MIN);
      count  <= '0;
      owp    <= 1'b0;
      orp    <= 1'b0;
      ocount <= '0;
    end else begin
      if (en) begin
        vw <= q_valid;
        v1 <= vw;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
      if (restart) begin
        best  <= SUM_W'(SUM_MIN);
        count <= '0;
      end else if (en && v4) begin
        best  <= best_next;
        count <= count_next;
      end
      if (opush) begin
        owp <= ~owp;
      end
      if (opop) begin
        orp <= ~orp;
      end
      if (opush && !opop) begin
        ocount <= ocount + 1'b1;
      end else if (opop && !opush) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

  assign res_out.valid      = (ocount != '0);
  assign res_out.center_row = obuf[orp].center_row;
  assign res_out.center_col = obuf[orp].center_col;
  assign res_out.window_sum = obuf[orp].window_sum;
  assign res_out.best_sum   = obuf[orp].best_sum;
  assign res_out.best_count = obuf[orp].best_count;
  assign res_out.last       = obuf[orp].last;
endmodule
`default_nettype wire
